@@ hw/rtl/sfpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sync frame parser.
// No dependencies; used by the channel interfaces, the top level and the checker.
package sfpc_pkg;

   // Largest payload length accepted, in 16-bit words
   localparam int unsigned MAX_LENGTH_WORDS = 255;

   // Running checksum width: seed plus header plus up to 255 words
   localparam int unsigned SUM_W   = 25;
   localparam int unsigned INDEX_W = 9;
   localparam int unsigned COUNT_W = 32;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST    = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND   = 2'd1;
   localparam logic [1:0] CSR_CHECKSUM_SEED = 2'd2;

   // One result beat
   typedef struct packed {
      logic                 payload_valid;
      logic [7:0]           payload_byte;
      logic [INDEX_W-1:0]   payload_index;
      logic                 frame_done;
      logic                 frame_good;
      logic [7:0]           frame_message_id;
      logic [7:0]           frame_words;
      logic [COUNT_W-1:0]   bad_sync1_count;
      logic [COUNT_W-1:0]   bad_sync2_count;
      logic [COUNT_W-1:0]   bad_sum_count;
   } rsp_beat_type;

endpackage

@@ hw/rtl/sfpc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the sync frame parser: byte input,
// result output and register write. Depends on sfpc_pkg.

// Raw byte stream
interface sfpc_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// Parser results
interface sfpc_rsp_if;
   logic                 valid;
   logic                 ready;
   sfpc_pkg::rsp_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

// Register writes
interface sfpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ hw/rtl/sync_frame_parser_with_sum_check.sv @@
`timescale 1ns / 1ps
// Sync / length / checksum frame parser, top level.
// Depends on sfpc_pkg and the channel interfaces in sfpc_if.sv.
//
// Usage:
//   req_ch carries one received byte per beat. Every accepted byte yields
//   exactly one beat on rsp_ch: payload bytes are passed on with their index
//   as they arrive, and the byte that ends a frame also carries frame_done,
//   frame_good, the message id and the length. The three saturating error
//   counters ride along on every result beat.
//   csr_ch writes sync_first (0), sync_second (1) and checksum_seed (2); it
//   is always ready, and writes to other indexes are dropped. Write it only
//   while no bytes are in flight.
// Result path and rate:
//   the parse state is updated in the cycle a byte is accepted; its result
//   goes to the output register, or to the skid register while a result
//   waits. One byte per cycle is sustained while rsp_ch stays ready.
// Stalls and reset:
//   a two-entry output stage (result register plus skid register) lets one
//   more byte in while a result waits; req_ch.ready drops only once both
//   entries are full. Reset empties both entries, clears the counters and
//   registers and restarts the hunt for the first sync byte.
module sync_frame_parser_with_sum_check (
   input  logic          clock,
   input  logic          reset,
   sfpc_byte_if.sink     req_ch,
   sfpc_rsp_if.source    rsp_ch,
   sfpc_csr_if.sink      csr_ch
);

   // Parse phase codes
   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_ID    = 3'd3;
   localparam logic [2:0] PH_SUMLO = 3'd4;
   localparam logic [2:0] PH_SUMHI = 3'd5;
   localparam logic [2:0] PH_DATA  = 3'd6;

   localparam int unsigned SUM_W   = sfpc_pkg::SUM_W;
   localparam int unsigned INDEX_W = sfpc_pkg::INDEX_W;
   localparam int unsigned COUNT_W = sfpc_pkg::COUNT_W;

   // Fold the carries above bit 15 back in once
   function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = s + (s >> 16);
      return t[15:0];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   // Configuration registers
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] seed_ff;

   // Parse state
   logic [2:0]         phase_ff,  phase_in;
   logic [7:0]         len_ff,    len_in;
   logic [7:0]         id_ff,     id_in;
   logic [15:0]        exp_ff,    exp_in;
   logic [INDEX_W-1:0] count_ff,  count_in;
   logic [SUM_W-1:0]   sum_ff,    sum_in;
   logic [7:0]         low_ff,    low_in;
   logic [COUNT_W-1:0] err1_ff,   err1_in;
   logic [COUNT_W-1:0] err2_ff,   err2_in;
   logic [COUNT_W-1:0] err3_ff,   err3_in;

   // Output stage
   logic                   out_valid_ff,  out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   sfpc_pkg::rsp_beat_type out_beat_ff,   out_beat_in;
   sfpc_pkg::rsp_beat_type skid_beat_ff,  skid_beat_in;
   sfpc_pkg::rsp_beat_type new_beat;

   logic                   accept;
   logic [7:0]             b;
   logic [SUM_W-1:0]       sum_add;
   logic [INDEX_W-1:0]     count_inc;
   logic [15:0]            exp_hi;
   logic                   good;
   logic                   finish;

   assign b      = req_ch.in_byte;
   assign accept = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.beat  = out_beat_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
         seed_ff        <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            sfpc_pkg::CSR_SYNC_FIRST:    sync_first_ff  <= csr_ch.wr_data[7:0];
            sfpc_pkg::CSR_SYNC_SECOND:   sync_second_ff <= csr_ch.wr_data[7:0];
            sfpc_pkg::CSR_CHECKSUM_SEED: seed_ff        <= csr_ch.wr_data;
            default: ;
         endcase
      end
   end

   // Per-byte state update and result
   assign sum_add   = sum_ff + SUM_W'({b, low_ff});
   assign count_inc = count_ff + INDEX_W'(1);
   assign exp_hi    = {b, exp_ff[7:0]};

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      exp_in   = exp_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      low_in   = low_ff;
      err1_in  = err1_ff;
      err2_in  = err2_ff;
      err3_in  = err3_ff;
      new_beat = '0;
      finish   = 1'b0;
      good     = 1'b0;

      unique case (phase_ff)
         PH_SYNC2: begin
            if (b != sync_second_ff) begin
               err2_in  = sat_inc(err2_ff);
               phase_in = PH_SYNC1;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (b > 8'(sfpc_pkg::MAX_LENGTH_WORDS)) begin
               phase_in = PH_SYNC1;
            end else begin
               len_in   = b;
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            id_in    = b;
            sum_in   = SUM_W'(seed_ff) + SUM_W'({b, len_ff});
            phase_in = PH_SUMLO;
         end
         PH_SUMLO: begin
            exp_in   = {8'd0, b};
            phase_in = PH_SUMHI;
         end
         PH_SUMHI: begin
            exp_in   = exp_hi;
            count_in = '0;
            if (len_ff == 8'd0) begin
               finish = 1'b1;
               good   = (fold_sum(sum_ff) == exp_hi);
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            new_beat.payload_valid = 1'b1;
            new_beat.payload_byte  = b;
            new_beat.payload_index = count_ff;
            // Even bytes are held as the low half, odd bytes close the word
            if (!count_ff[0]) begin
               low_in = b;
            end else begin
               sum_in = sum_add;
            end
            count_in = count_inc;
            if (count_inc >= {len_ff, 1'b0}) begin
               finish = 1'b1;
               good   = (fold_sum(count_ff[0] ? sum_add : sum_ff) == exp_ff);
            end
         end
         default: begin
            // Hunting for the first sync byte; unused codes land here too
            if (b != sync_first_ff) begin
               err1_in  = sat_inc(err1_ff);
               phase_in = PH_SYNC1;
            end else begin
               phase_in = PH_SYNC2;
            end
         end
      endcase

      // Frame report
      if (finish) begin
         new_beat.frame_done       = 1'b1;
         new_beat.frame_good       = good;
         new_beat.frame_message_id = id_ff;
         new_beat.frame_words      = len_ff;
         if (!good) begin
            err3_in = sat_inc(err3_ff);
         end
         phase_in = PH_SYNC1;
      end

      // Back to the hunt clears the frame context but for the message id
      if (phase_in == PH_SYNC1) begin
         len_in   = '0;
         exp_in   = '0;
         count_in = '0;
         sum_in   = '0;
         low_in   = '0;
      end

      new_beat.bad_sync1_count = err1_in;
      new_beat.bad_sync2_count = err2_in;
      new_beat.bad_sum_count   = err3_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         len_ff   <= '0;
         id_ff    <= '0;
         exp_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         low_ff   <= '0;
         err1_ff  <= '0;
         err2_ff  <= '0;
         err3_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         exp_ff   <= exp_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         low_ff   <= low_in;
         err1_ff  <= err1_in;
         err2_ff  <= err2_in;
         err3_ff  <= err3_in;
      end
   end

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_beat_in  = new_beat;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = new_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

endmodule

@@ hw/rtl/sfpc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the sync frame parser, bound to the top level.
// Depends on sfpc_pkg and sync_frame_parser_with_sum_check.
module sfpc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sfpc_pkg::rsp_beat_type rsp_beat
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   // A good flag only on a completed frame, with the report fields zero otherwise
   a_good_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beat.frame_done |->
         !rsp_beat.frame_good && rsp_beat.frame_message_id == 8'd0
         && rsp_beat.frame_words == 8'd0)
      else $error("frame report without frame_done");

   // Non-payload beats carry a zero byte and index
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beat.payload_valid |->
         rsp_beat.payload_byte == 8'd0 && rsp_beat.payload_index == '0)
      else $error("payload fields set on a non-payload beat");

   // Reset empties the output stage and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output stage not empty after reset");

endmodule

bind sync_frame_parser_with_sum_check sfpc_checker u_sfpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_beat  (rsp_ch.beat)
);
